FILE: design/gpsrl_pkg.sv
`timescale 1ns / 1ps

package gpsrl_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_FOLLOW_ENABLED  = 2'd0;
   localparam logic [1:0] REG_SMOOTHING_ALPHA = 2'd1;
   localparam logic [1:0] REG_MIN_INTERVAL_MS = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam int ALPHA_W     = 17;
   localparam int INTERVAL_W  = 10;
   localparam int GAZE_W      = 16;
   localparam int PIXEL_W     = 12;
   localparam int TIME_W      = 32;
   localparam int SMOOTH_W    = 28;   // Q12.16 value of a Q12.4 sample fits in 28 bits

   // Alpha in Q1.16, clamped to 0.05 .. 1.0
   localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 17'd3277;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd19661;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd16;

   localparam logic signed [PIXEL_W-1:0] PIXEL_MAX = 12'sd2047;

endpackage

FILE: design/gaze_point_smoother_rate_limited_core.sv
`timescale 1ns / 1ps
// A request beat is taken into the input register; its result, if it emits, is
// registered in the output register, whose valid flag drives rsp_tvalid.
// Throughput: one request beat per cycle while the output register is empty or
// rsp_tready is high. The input and output registers part the two sides, so a beat
// is still taken into an empty input register while a result waits on rsp_tready.
// Reset (synchronous, active high) disables following, loads alpha 19661 and a
// 16 ms interval, and clears the filter and emit history.
module gaze_point_smoother_rate_limited_core (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,   // gaze_x, gaze_y, now_ms
   input  logic [1:0]                        req_tuser,   // sample_valid, pause_input
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // pointer_x, pointer_y
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gpsrl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gpsrl_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gpsrl_pkg::*;

   // ---------------- configuration registers ----------------
   logic                  follow_enabled_ff,  follow_enabled_in;
   logic [ALPHA_W-1:0]    alpha_ff,           alpha_in;
   logic [INTERVAL_W-1:0] min_interval_ff,    min_interval_in;

   // ---------------- filter and emit history ----------------
   logic                        seeded_ff,     seeded_in;
   logic signed [SMOOTH_W-1:0]  smooth_x_ff,   smooth_x_in;
   logic signed [SMOOTH_W-1:0]  smooth_y_ff,   smooth_y_in;
   logic signed [PIXEL_W-1:0]   last_px_ff,    last_px_in;
   logic signed [PIXEL_W-1:0]   last_py_ff,    last_py_in;
   logic                        emitted_ff,    emitted_in;
   logic [TIME_W-1:0]           last_emit_ff,  last_emit_in;

   // ---------------- input register ----------------
   logic                      in_valid_ff, in_valid_in;
   logic signed [GAZE_W-1:0]  in_gx_ff,    in_gx_in;
   logic signed [GAZE_W-1:0]  in_gy_ff,    in_gy_in;
   logic                      in_sv_ff,    in_sv_in;
   logic                      in_pause_ff, in_pause_in;
   logic [TIME_W-1:0]         in_now_ff,   in_now_in;

   // ---------------- output register ----------------
   logic                      out_valid_ff, out_valid_in;
   logic signed [PIXEL_W-1:0] out_px_ff,    out_px_in;
   logic signed [PIXEL_W-1:0] out_py_ff,    out_py_in;

   // ---------------- datapath wires ----------------
   logic advance, in_load, process, take, emit, differ, limited, csr_write;
   logic [ALPHA_W-1:0]         beta;
   logic signed [ALPHA_W:0]    alpha_s, beta_s;
   logic signed [SMOOTH_W-1:0] gx_q, gy_q, ema_x, ema_y, new_x, new_y;
   logic signed [PIXEL_W-1:0]  px, py;
   logic [TIME_W-1:0]          dt;

   // EMA on one axis: round((s*(1-a) + g*a) / 2^16), halves away from zero.
   // Negative sums take a bias of 2^15-1 so the floor shift rounds the
   // magnitude the same way as positive ones.
   function automatic logic signed [SMOOTH_W-1:0] ema_axis(
      input logic signed [SMOOTH_W-1:0] s,
      input logic signed [SMOOTH_W-1:0] g,
      input logic signed [ALPHA_W:0]    wa,
      input logic signed [ALPHA_W:0]    wb
   );
      logic signed [SMOOTH_W+ALPHA_W:0]   ps, pg;
      logic signed [SMOOTH_W+ALPHA_W+1:0] acc, rnd;
      ps  = s * wb;
      pg  = g * wa;
      acc = (SMOOTH_W+ALPHA_W+2)'(ps) + (SMOOTH_W+ALPHA_W+2)'(pg);
      rnd = acc + (acc[SMOOTH_W+ALPHA_W+1] ? (SMOOTH_W+ALPHA_W+2)'(32767)
                                           : (SMOOTH_W+ALPHA_W+2)'(32768));
      return rnd[SMOOTH_W+15:16];
   endfunction

   // Q12.16 to whole pixels, halves away from zero; only the top end can clip.
   function automatic logic signed [PIXEL_W-1:0] to_pixel(
      input logic signed [SMOOTH_W-1:0] s
   );
      logic signed [SMOOTH_W:0]   sum;
      logic signed [PIXEL_W:0]    p;
      sum = {s[SMOOTH_W-1], s} + (s[SMOOTH_W-1] ? (SMOOTH_W+1)'(32767)
                                                : (SMOOTH_W+1)'(32768));
      p   = sum[SMOOTH_W:16];
      return (p > (PIXEL_W+1)'(PIXEL_MAX)) ? PIXEL_MAX : p[PIXEL_W-1:0];
   endfunction

   // ---------------- handshakes ----------------
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign in_load    = req_tvalid && req_tready;
   assign process    = in_valid_ff && advance;
   assign take       = process && follow_enabled_ff && in_sv_ff && !in_pause_ff;

   // ---------------- filter ----------------
   assign beta    = ALPHA_ONE - alpha_ff;
   assign alpha_s = {1'b0, alpha_ff};
   assign beta_s  = {1'b0, beta};
   // Q12.4 -> Q12.16: sign-extend, then scale by 2^12
   assign gx_q    = SMOOTH_W'(in_gx_ff) <<< 12;
   assign gy_q    = SMOOTH_W'(in_gy_ff) <<< 12;
   assign ema_x   = ema_axis(smooth_x_ff, gx_q, alpha_s, beta_s);
   assign ema_y   = ema_axis(smooth_y_ff, gy_q, alpha_s, beta_s);
   // first accepted sample seeds the filter
   assign new_x   = seeded_ff ? ema_x : gx_q;
   assign new_y   = seeded_ff ? ema_y : gy_q;
   assign px      = to_pixel(new_x);
   assign py      = to_pixel(new_y);

   // ---------------- move decision ----------------
   assign differ  = (px != last_px_ff) || (py != last_py_ff);
   assign dt      = in_now_ff - last_emit_ff;          // modulo 2^32
   assign limited = emitted_ff && (dt < {{(TIME_W-INTERVAL_W){1'b0}}, min_interval_ff});
   assign emit    = take && differ && !limited;

   always_comb begin
      // input register
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      in_gx_in    = in_load ? req_tdata[15:0]  : in_gx_ff;
      in_gy_in    = in_load ? req_tdata[31:16] : in_gy_ff;
      in_now_in   = in_load ? req_tdata[63:32] : in_now_ff;
      in_sv_in    = in_load ? req_tuser[0]     : in_sv_ff;
      in_pause_in = in_load ? req_tuser[1]     : in_pause_ff;

      // output register
      out_valid_in = out_valid_ff;
      if (process) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      out_px_in = emit ? px : out_px_ff;
      out_py_in = emit ? py : out_py_ff;

      // state
      seeded_in    = seeded_ff;
      smooth_x_in  = smooth_x_ff;
      smooth_y_in  = smooth_y_ff;
      last_px_in   = last_px_ff;
      last_py_in   = last_py_ff;
      emitted_in   = emitted_ff;
      last_emit_in = last_emit_ff;
      if (take) begin
         seeded_in   = 1'b1;
         smooth_x_in = new_x;
         smooth_y_in = new_y;
      end
      if (emit) begin
         emitted_in   = 1'b1;
         last_emit_in = in_now_ff;
         last_px_in   = px;
         last_py_in   = py;
      end

      // register writes; any enable write wipes the history
      follow_enabled_in = follow_enabled_ff;
      alpha_in          = alpha_ff;
      min_interval_in   = min_interval_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FOLLOW_ENABLED: begin
               follow_enabled_in = csr_data[0];
               seeded_in         = 1'b0;
               smooth_x_in       = '0;
               smooth_y_in       = '0;
               last_px_in        = '0;
               last_py_in        = '0;
               emitted_in        = 1'b0;
               last_emit_in      = '0;
            end
            REG_SMOOTHING_ALPHA: begin
               if (csr_data[ALPHA_W-1:0] < ALPHA_MIN) begin
                  alpha_in = ALPHA_MIN;
               end else if (csr_data[ALPHA_W-1:0] > ALPHA_ONE) begin
                  alpha_in = ALPHA_ONE;
               end else begin
                  alpha_in = csr_data[ALPHA_W-1:0];
               end
            end
            REG_MIN_INTERVAL_MS: begin
               min_interval_in = csr_data[INTERVAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         follow_enabled_ff <= 1'b0;
         alpha_ff          <= ALPHA_RESET;
         min_interval_ff   <= INTERVAL_RESET;
         seeded_ff         <= 1'b0;
         smooth_x_ff       <= '0;
         smooth_y_ff       <= '0;
         last_px_ff        <= '0;
         last_py_ff        <= '0;
         emitted_ff        <= 1'b0;
         last_emit_ff      <= '0;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         follow_enabled_ff <= follow_enabled_in;
         alpha_ff          <= alpha_in;
         min_interval_ff   <= min_interval_in;
         seeded_ff         <= seeded_in;
         smooth_x_ff       <= smooth_x_in;
         smooth_y_ff       <= smooth_y_in;
         last_px_ff        <= last_px_in;
         last_py_ff        <= last_py_in;
         emitted_ff        <= emitted_in;
         last_emit_ff      <= last_emit_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_gx_ff    <= in_gx_in;
      in_gy_ff    <= in_gy_in;
      in_now_ff   <= in_now_in;
      in_sv_ff    <= in_sv_in;
      in_pause_ff <= in_pause_in;
      out_px_ff   <= out_px_in;
      out_py_ff   <= out_py_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_py_ff, out_px_ff};

endmodule
